>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the striped query profile builder.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int MAX_QUERY_DEF  = 4096;
	localparam int ALPHABET_DEF   = 20;
	localparam int BYTE_LANES_DEF = 16;
	localparam int WORD_LANES_DEF = 8;

	// at most this many lanes per vector
	localparam int MAX_RESULTS = 16;

	localparam int LANE_W   = 4;
	localparam int RES_W    = 5;
	localparam int SEG_W    = 9;
	localparam int SCORE_W  = 8;
	localparam int VALUE_W  = 16;
	localparam int BIAS_W   = 8;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// register index as seen on paddr[2]
	localparam logic REG_WORD_MODE = 1'b0;
	localparam logic REG_BIAS      = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_EMIT   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [RES_W-1:0]    row;
		logic [RES_W-1:0]    col;
		logic [SCORE_W-1:0]  score;
		logic [RES_W-1:0]    residue;
		logic [SEG_W-1:0]    segment;
		logic                res_ok;
	} spq_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/spq_front.sv
// ----------------------------------------------------------------------------
// spq_front
// Accepts items, drops those that leave no trace, decodes the rest into
// commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_front #(
	parameter int ALPHABET = spq_pkg::ALPHABET_DEF
) (
	input  logic                        start,
	input  logic [1:0]                  kind,
	input  logic [spq_pkg::RES_W-1:0]   row_index,
	input  logic [spq_pkg::RES_W-1:0]   col_index,
	input  logic signed [spq_pkg::SCORE_W-1:0] score,
	input  logic [spq_pkg::RES_W-1:0]   residue,
	input  logic [spq_pkg::SEG_W-1:0]   segment,
	input  logic                        queue_full,
	output logic                        busy,
	output logic                        push,
	output spq_pkg::spq_cmd_t           cmd
);
	import spq_pkg::*;

	localparam logic [RES_W:0] ALPHA_L = (RES_W+1)'(ALPHABET);

	logic row_ok;
	logic col_ok;
	logic res_ok;
	logic keep;
	kind_t kind_d;

	assign row_ok = {1'b0, row_index} < ALPHA_L;
	assign col_ok = {1'b0, col_index} < ALPHA_L;
	assign res_ok = {1'b0, residue} < ALPHA_L;
	assign kind_d = kind_t'(kind);

	always_comb begin
		case (kind_d)
			KIND_WRITE:  keep = row_ok & col_ok;
			KIND_APPEND: keep = res_ok;
			KIND_CLEAR:  keep = 1'b1;
			KIND_EMIT:   keep = 1'b1;
			default:     keep = 1'b0;
		endcase
	end

	assign busy = queue_full;
	// drop out-of-range writes and appends at the door
	assign push = start & ~queue_full & keep;

	always_comb begin
		cmd.kind    = kind_d;
		cmd.row     = row_index;
		cmd.col     = col_index;
		cmd.score   = score;
		cmd.residue = residue;
		cmd.segment = segment;
		cmd.res_ok  = res_ok;
	end

endmodule

`default_nettype wire

>>> hw/rtl/spq_queue.sv
// ----------------------------------------------------------------------------
// spq_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  spq_pkg::spq_cmd_t  cmd_in,
	input  logic               pop,
	output spq_pkg::spq_cmd_t  head,
	output logic               empty,
	output logic               full
);
	import spq_pkg::*;

	spq_cmd_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/spq_back.sv
// ----------------------------------------------------------------------------
// spq_back
// Executes queued commands: owns the score table, the query store and the
// query length, and streams one profile vector lane by lane.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_back #(
	parameter int MAX_QUERY  = spq_pkg::MAX_QUERY_DEF,
	parameter int ALPHABET   = spq_pkg::ALPHABET_DEF,
	parameter int BYTE_LANES = spq_pkg::BYTE_LANES_DEF,
	parameter int WORD_LANES = spq_pkg::WORD_LANES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         word_mode,
	input  logic [spq_pkg::BIAS_W-1:0]   bias,
	input  spq_pkg::spq_cmd_t            head,
	input  logic                         empty,
	output logic                         pop,
	output logic                         valid,
	output logic [spq_pkg::VALUE_W-1:0]  value,
	output logic [spq_pkg::LANE_W-1:0]   lane,
	output logic                         is_padding,
	output logic                         last
);
	import spq_pkg::*;

	localparam int QLW  = $clog2(MAX_QUERY + 1);
	localparam int QAW  = $clog2(MAX_QUERY);
	localparam int TDEP = ALPHABET * ALPHABET;
	localparam int TAW  = $clog2(TDEP);
	localparam int JW   = ((QLW > SEG_W) ? QLW : SEG_W) + 5;
	localparam int LB   = (BYTE_LANES > MAX_RESULTS) ? MAX_RESULTS : BYTE_LANES;
	localparam int LW   = (WORD_LANES > MAX_RESULTS) ? MAX_RESULTS : WORD_LANES;
	localparam logic [LANE_W-1:0] LB_M1 = LANE_W'(LB - 1);
	localparam logic [LANE_W-1:0] LW_M1 = LANE_W'(LW - 1);
	localparam logic [QLW-1:0]    QMAX  = QLW'(MAX_QUERY);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t               state_q;
	logic [QLW-1:0]       qlen_q;
	logic [QLW-1:0]       seglen_b_q;
	logic [QLW-1:0]       seglen_w_q;
	logic [LANE_W-1:0]    rem_b_q;
	logic [LANE_W-1:0]    rem_w_q;
	logic [JW-1:0]        j_q;
	logic [LANE_W-1:0]    k_q;
	logic [RES_W-1:0]     res_q;
	logic                 res_ok_q;

	logic                 vld_s1;
	logic                 pad_s1;
	logic [LANE_W-1:0]    lane_s1;
	logic                 last_s1;
	logic [RES_W-1:0]     q_rd_s1;

	logic                 vld_s2;
	logic                 pad_s2;
	logic [LANE_W-1:0]    lane_s2;
	logic                 last_s2;
	logic [SCORE_W-1:0]   t_rd_s2;

	logic                 valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic [LANE_W-1:0]    lane_q;
	logic                 pad_q;
	logic                 last_q;

	logic [RES_W-1:0]     qmem [MAX_QUERY];
	logic [SCORE_W-1:0]   tmem [TDEP];

	logic                 q_we;
	logic                 t_we;
	logic [QAW-1:0]       q_raddr;
	logic [TAW-1:0]       t_waddr;
	logic [TAW-1:0]       t_raddr;
	logic [QLW-1:0]       seglen_sel;
	logic [LANE_W-1:0]    lanes_m1;
	logic                 issue_pad;
	logic [SCORE_W-1:0]   raw;
	logic [SCORE_W-1:0]   byte_sum;
	logic [VALUE_W-1:0]   value_d;

	assign pop        = (state_q == ST_IDLE) & ~empty;
	assign q_we       = pop & (head.kind == KIND_APPEND) & (qlen_q < QMAX);
	assign t_we       = pop & (head.kind == KIND_WRITE);
	assign q_raddr    = j_q[QAW-1:0];
	assign t_waddr    = TAW'(32'(head.row) * ALPHABET + 32'(head.col));
	assign t_raddr    = TAW'(32'(q_rd_s1) * ALPHABET + 32'(res_q));
	assign seglen_sel = word_mode ? seglen_w_q : seglen_b_q;
	assign lanes_m1   = word_mode ? LW_M1 : LB_M1;
	assign issue_pad  = (j_q >= JW'(qlen_q));

	// a bad profile residue scores zero on every real lane
	assign raw      = res_ok_q ? t_rd_s2 : '0;
	assign byte_sum = raw + bias;

	always_comb begin
		if (word_mode) begin
			value_d = pad_s2 ? '0 : {{(VALUE_W-SCORE_W){raw[SCORE_W-1]}}, raw};
		end else begin
			value_d = {{(VALUE_W-SCORE_W){1'b0}}, pad_s2 ? bias : byte_sum};
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[qlen_q[QAW-1:0]] <= head.residue;
		end
		q_rd_s1 <= qmem[q_raddr];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_waddr] <= head.score;
		end
		t_rd_s2 <= tmem[t_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			qlen_q     <= '0;
			seglen_b_q <= '0;
			seglen_w_q <= '0;
			rem_b_q    <= '0;
			rem_w_q    <= '0;
			j_q        <= '0;
			k_q        <= '0;
			res_q      <= '0;
			res_ok_q   <= 1'b0;
			vld_s1     <= 1'b0;
			pad_s1     <= 1'b0;
			lane_s1    <= '0;
			last_s1    <= 1'b0;
			vld_s2     <= 1'b0;
			pad_s2     <= 1'b0;
			lane_s2    <= '0;
			last_s2    <= 1'b0;
			valid_q    <= 1'b0;
			value_q    <= '0;
			lane_q     <= '0;
			pad_q      <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.kind)
							KIND_APPEND: begin
								if (q_we) begin
									qlen_q <= qlen_q + 1'b1;
									// track ceil(qlen/lanes) for both lane counts
									if (rem_b_q == '0) begin
										seglen_b_q <= seglen_b_q + 1'b1;
									end
									if (rem_w_q == '0) begin
										seglen_w_q <= seglen_w_q + 1'b1;
									end
									rem_b_q <= (rem_b_q == LB_M1) ? '0 : rem_b_q + 1'b1;
									rem_w_q <= (rem_w_q == LW_M1) ? '0 : rem_w_q + 1'b1;
								end
							end
							KIND_CLEAR: begin
								qlen_q     <= '0;
								seglen_b_q <= '0;
								seglen_w_q <= '0;
								rem_b_q    <= '0;
								rem_w_q    <= '0;
							end
							KIND_EMIT: begin
								j_q      <= JW'(head.segment);
								k_q      <= '0;
								res_q    <= head.residue;
								res_ok_q <= head.res_ok;
								state_q  <= ST_ISSUE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ISSUE: begin
					vld_s1  <= 1'b1;
					pad_s1  <= issue_pad;
					lane_s1 <= k_q;
					last_s1 <= (k_q == lanes_m1);
					j_q     <= j_q + JW'(seglen_sel);
					k_q     <= k_q + 1'b1;
					if (k_q == lanes_m1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold off table writes until the last lane has read
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			vld_s2  <= vld_s1;
			pad_s2  <= pad_s1;
			lane_s2 <= lane_s1;
			last_s2 <= last_s1;

			valid_q <= vld_s2;
			value_q <= value_d;
			lane_q  <= lane_s2;
			pad_q   <= pad_s2;
			last_q  <= last_s2;
		end
	end

	assign valid      = valid_q;
	assign value      = value_q;
	assign lane       = lane_q;
	assign is_padding = pad_q;
	assign last       = last_q;

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> (!vld_s1 && !vld_s2))
		else $error("table written while a vector is in flight");

	a_last_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (lane_q == lanes_m1))
		else $error("last flag on wrong lane");

	a_issue_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |=> vld_s1)
		else $error("issued lane did not enter stage one");

	a_qlen_cap: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= QMAX)
		else $error("query length beyond capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> valid_q)
		else $error("lane lost between stage two and output");

endmodule

`default_nettype wire

>>> hw/rtl/striped_query_profile_builder.sv
// ----------------------------------------------------------------------------
// striped_query_profile_builder
// Striped query profile builder: holds a substitution table and a query and
// emits one striped profile vector per request, one lane per result.
//
//   channel   ports                                          handshake
//   command   kind row_index col_index score residue segment start / busy
//   result    value lane is_padding last                     valid strobe
//   config    paddr pwdata prdata                            psel penable pwrite
//
// Table writes, appends and clears are executed by the back end when idle.
// A vector request streams its lanes (16 in byte mode, 8 in word mode),
// paced by the single read port of the query store and the score table;
// each lane passes the query read, the table read and the output register.
// busy is high while the four-entry command queue is full.
// Reset clears the query length and the registers; table and query contents
// are undefined until written. Results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module striped_query_profile_builder #(
	parameter int MAX_QUERY  = spq_pkg::MAX_QUERY_DEF,
	parameter int ALPHABET   = spq_pkg::ALPHABET_DEF,
	parameter int BYTE_LANES = spq_pkg::BYTE_LANES_DEF,
	parameter int WORD_LANES = spq_pkg::WORD_LANES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spq_pkg::ADDR_W-1:0]          paddr,
	input  logic [spq_pkg::DATA_W-1:0]          pwdata,
	output logic [spq_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          kind,
	input  logic [spq_pkg::RES_W-1:0]           row_index,
	input  logic [spq_pkg::RES_W-1:0]           col_index,
	input  logic signed [spq_pkg::SCORE_W-1:0]  score,
	input  logic [spq_pkg::RES_W-1:0]           residue,
	input  logic [spq_pkg::SEG_W-1:0]           segment,
	output logic                                valid,
	output logic [spq_pkg::VALUE_W-1:0]         value,
	output logic [spq_pkg::LANE_W-1:0]          lane,
	output logic                                is_padding,
	output logic                                last
);
	import spq_pkg::*;

	logic                word_mode_q;
	logic [BIAS_W-1:0]   bias_q;
	logic                cfg_we;
	logic                push;
	logic                pop;
	logic                empty;
	logic                full;
	spq_cmd_t            cmd;
	spq_cmd_t            head;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_mode_q <= 1'b0;
			bias_q      <= '0;
		end else if (cfg_we) begin
			case (paddr[2])
				REG_WORD_MODE: word_mode_q <= pwdata[0];
				REG_BIAS:      bias_q      <= pwdata[BIAS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WORD_MODE: prdata = {{(DATA_W-1){1'b0}}, word_mode_q};
			REG_BIAS:      prdata = {{(DATA_W-BIAS_W){1'b0}}, bias_q};
			default:       prdata = '0;
		endcase
	end

	spq_front #(
		.ALPHABET (ALPHABET)
	) u_front (
		.start      (start),
		.kind       (kind),
		.row_index  (row_index),
		.col_index  (col_index),
		.score      (score),
		.residue    (residue),
		.segment    (segment),
		.queue_full (full),
		.busy       (busy),
		.push       (push),
		.cmd        (cmd)
	);

	spq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	spq_back #(
		.MAX_QUERY  (MAX_QUERY),
		.ALPHABET   (ALPHABET),
		.BYTE_LANES (BYTE_LANES),
		.WORD_LANES (WORD_LANES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_mode  (word_mode_q),
		.bias       (bias_q),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.valid      (valid),
		.value      (value),
		.lane       (lane),
		.is_padding (is_padding),
		.last       (last)
	);

endmodule

`default_nettype wire

>>> tb/tb_striped_query_profile_builder.sv
// ----------------------------------------------------------------------------
// tb_striped_query_profile_builder
// Self-checking bench for the striped query profile builder. A driver pulls
// commands from a backlog filled by the stimulus process. Each accepted
// command updates a local copy of the score table and query, and each vector
// request pushes its lane values. A monitor compares every result strobe
// against the oldest predicted lane.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_striped_query_profile_builder;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int ALPHA      = ALPHABET_DEF;
	localparam int MAXQ       = MAX_QUERY_DEF;
	localparam int QUIET_MAX  = 2000;
	localparam logic [ADDR_W-1:0] ADDR_WORD_MODE = {REG_WORD_MODE, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_BIAS      = {REG_BIAS, 2'b00};

	typedef struct {
		kind_t               kind;
		logic [RES_W-1:0]    row;
		logic [RES_W-1:0]    col;
		logic [SCORE_W-1:0]  score;
		logic [RES_W-1:0]    residue;
		logic [SEG_W-1:0]    segment;
	} cmd_t;

	typedef struct {
		logic [VALUE_W-1:0]  value;
		logic [LANE_W-1:0]   lane;
		logic                pad;
		logic                last;
	} lane_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = '0;
	logic [RES_W-1:0] row_index = '0;
	logic [RES_W-1:0] col_index = '0;
	logic signed [SCORE_W-1:0] score = '0;
	logic [RES_W-1:0] residue = '0;
	logic [SEG_W-1:0] segment = '0;
	logic valid;
	logic [VALUE_W-1:0] value;
	logic [LANE_W-1:0] lane;
	logic is_padding;
	logic last;

	striped_query_profile_builder u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.kind(kind), .row_index(row_index), .col_index(col_index), .score(score),
		.residue(residue), .segment(segment),
		.valid(valid), .value(value), .lane(lane), .is_padding(is_padding),
		.last(last)
	);

	always #5 clk = ~clk;

	// predicted block state, advanced on each accepted command
	logic [7:0] score_tbl [ALPHA][ALPHA];
	logic [RES_W-1:0] query_mem [MAXQ];
	int query_len = 0;
	logic cfg_word_mode = 1'b0;
	logic [7:0] cfg_bias = '0;

	// stimulus-side view, used to keep vector requests on written table entries
	bit gen_written [ALPHA*ALPHA];
	bit [ALPHA-1:0] gen_present = '0;
	int gen_len = 0;
	int issued = 0;

	cmd_t cmd_backlog [$];
	lane_t expected_lanes [$];
	cmd_t cur_cmd;
	lane_t got_lane;
	int gap_left = 0;
	bit gaps_on = 1'b1;
	int quiet_cycles = 0;
	int fail_count = 0;

	function automatic void apply_command(cmd_t c);
		int lanes;
		int seg_len;
		int j;
		lane_t e;
		logic [7:0] raw;
		logic [7:0] biased;
		case (c.kind)
			KIND_WRITE: begin
				if (c.row < ALPHA && c.col < ALPHA)
					score_tbl[c.row][c.col] = c.score;
			end
			KIND_APPEND: begin
				if (query_len < MAXQ && c.residue < ALPHA) begin
					query_mem[query_len] = c.residue;
					query_len++;
				end
			end
			KIND_CLEAR: query_len = 0;
			KIND_EMIT: begin
				lanes = cfg_word_mode ? WORD_LANES_DEF : BYTE_LANES_DEF;
				if (lanes > MAX_RESULTS)
					lanes = MAX_RESULTS;
				seg_len = (query_len + lanes - 1) / lanes;
				for (int k = 0; k < lanes; k++) begin
					j = c.segment + k * seg_len;
					e.lane = k[LANE_W-1:0];
					e.last = (k == lanes - 1);
					e.pad = (j >= query_len);
					if (e.pad) begin
						e.value = cfg_word_mode ? '0 : {8'h00, cfg_bias};
					end else begin
						raw = (c.residue < ALPHA) ? score_tbl[query_mem[j]][c.residue] : 8'h00;
						biased = raw + cfg_bias;
						e.value = cfg_word_mode ? {{8{raw[7]}}, raw} : {8'h00, biased};
					end
					expected_lanes.push_back(e);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_residue();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(ALPHA, 31);
		return $urandom_range(0, ALPHA - 1);
	endfunction

	// unused fields still carry random content
	function automatic cmd_t rand_cmd(kind_t k);
		cmd_t c;
		c.kind = k;
		c.row = RES_W'($urandom_range(0, 31));
		c.col = RES_W'($urandom_range(0, 31));
		c.score = SCORE_W'($urandom_range(0, 255));
		c.residue = RES_W'($urandom_range(0, 31));
		c.segment = SEG_W'($urandom_range(0, 511));
		return c;
	endfunction

	function automatic void queue_write(int r, int c_idx, logic [7:0] s);
		cmd_t c;
		c = rand_cmd(KIND_WRITE);
		c.row = RES_W'(r);
		c.col = RES_W'(c_idx);
		c.score = s;
		if (r < ALPHA && c_idx < ALPHA)
			gen_written[r * ALPHA + c_idx] = 1'b1;
		cmd_backlog.push_back(c);
		issued++;
	endfunction

	function automatic void queue_append(int res);
		cmd_t c;
		c = rand_cmd(KIND_APPEND);
		c.residue = RES_W'(res);
		if (gen_len < MAXQ && res < ALPHA) begin
			gen_present[res] = 1'b1;
			gen_len++;
		end
		cmd_backlog.push_back(c);
		issued++;
	endfunction

	function automatic void queue_clear();
		gen_len = 0;
		gen_present = '0;
		cmd_backlog.push_back(rand_cmd(KIND_CLEAR));
		issued++;
	endfunction

	// fill any table entry in column a that the current query could read
	function automatic void queue_emit(int a, int seg);
		cmd_t c;
		if (a < ALPHA)
			for (int q = 0; q < ALPHA; q++)
				if (gen_present[q] && !gen_written[q * ALPHA + a])
					queue_write(q, a, 8'($urandom_range(0, 255)));
		c = rand_cmd(KIND_EMIT);
		c.residue = RES_W'(a);
		c.segment = SEG_W'(seg);
		cmd_backlog.push_back(c);
		issued++;
	endfunction

	function automatic void random_phase(int n);
		int target;
		int r;
		int lanes;
		int seg_len;
		int seg;
		target = issued + n;
		while (issued < target) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				queue_clear();
				repeat ($urandom_range(1, 40)) queue_append(pick_residue());
			end else if (r < 25) begin
				repeat ($urandom_range(1, 8)) queue_append(pick_residue());
			end else if (r < 35) begin
				if ($urandom_range(0, 6) == 0)
					queue_write($urandom_range(0, 31), $urandom_range(0, 31),
						8'($urandom_range(0, 255)));
				else
					queue_write($urandom_range(0, ALPHA - 1), $urandom_range(0, ALPHA - 1),
						8'($urandom_range(0, 255)));
			end else if (r < 38) begin
				queue_clear();
			end else begin
				lanes = cfg_word_mode ? WORD_LANES_DEF : BYTE_LANES_DEF;
				seg_len = (gen_len + lanes - 1) / lanes;
				if (seg_len > 0 && $urandom_range(0, 4) != 0)
					seg = $urandom_range(0, seg_len - 1);
				else
					seg = $urandom_range(0, 511);
				queue_emit(pick_residue(), seg);
			end
		end
	endfunction

	task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(logic wm, logic [7:0] b);
		cfg_write(ADDR_WORD_MODE, {31'd0, wm});
		cfg_write(ADDR_BIAS, {24'd0, b});
		cfg_word_mode = wm;
		cfg_bias = b;
	endtask

	// wait for the backlog and all lanes, then let queued table work finish
	task automatic settle();
		while (cmd_backlog.size() != 0 || start || expected_lanes.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				apply_command(cur_cmd);
			if (start && busy) begin
				// hold the current transfer until the block takes it
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_backlog.size() != 0) begin
				cur_cmd = cmd_backlog.pop_front();
				kind <= cur_cmd.kind;
				row_index <= cur_cmd.row;
				col_index <= cur_cmd.col;
				score <= cur_cmd.score;
				residue <= cur_cmd.residue;
				segment <= cur_cmd.segment;
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (expected_lanes.size() == 0) begin
				$error("result with nothing expected: lane %0d value %h", lane, value);
				fail_count++;
			end else begin
				got_lane = expected_lanes.pop_front();
				if (value !== got_lane.value) begin
					$error("value: expected %h, got %h", got_lane.value, value);
					fail_count++;
				end
				if (lane !== got_lane.lane) begin
					$error("lane: expected %0d, got %0d", got_lane.lane, lane);
					fail_count++;
				end
				if (is_padding !== got_lane.pad) begin
					$error("is_padding: expected %b, got %b", got_lane.pad, is_padding);
					fail_count++;
				end
				if (last !== got_lane.last) begin
					$error("last: expected %b, got %b", got_lane.last, last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_MAX) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic wm_set [6];
		logic [7:0] bias_set [6];
		wm_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		bias_set = '{8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00};
		bias_set[4] = 8'($urandom_range(1, 254));
		bias_set[5] = 8'($urandom_range(1, 254));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// byte mode corners: empty query, score extremes, rejected writes and appends
		set_regs(1'b0, 8'h00);
		queue_emit(5, 0);
		queue_write(ALPHA - 1, ALPHA - 1, 8'h7f);
		queue_write(0, 0, 8'h80);
		queue_write(ALPHA, 3, 8'h05);
		queue_write(4, 31, 8'hff);
		queue_write(31, 31, 8'h11);
		queue_append(0);
		queue_append(ALPHA - 1);
		queue_append(ALPHA);
		queue_append(31);
		queue_append(7);
		queue_emit(0, 0);
		queue_emit(ALPHA - 1, 0);
		queue_emit(31, 0);
		queue_emit(ALPHA - 1, 511);
		queue_clear();
		queue_emit(0, 0);
		settle();

		// word mode corners
		set_regs(1'b1, 8'hff);
		queue_append(ALPHA - 1);
		queue_append(0);
		queue_emit(0, 0);
		queue_emit(ALPHA - 1, 1);
		queue_emit(31, 0);
		queue_emit(2, 511);
		settle();

		for (int p = 0; p < 6; p++) begin
			set_regs(wm_set[p], bias_set[p]);
			gaps_on = (p != 2);
			random_phase(45);
			settle();
		end

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
